@@ hdl/dscg_pkg.sv @@
package dscg_pkg;

  // Samples in one sine period; must be a power of two.
  localparam int SPP    = 1024;
  localparam int PH_W   = $clog2(SPP);
  localparam int ANG_W  = PH_W + 1;

  localparam int Q_FRAC = 30;
  localparam int PIH_W  = 31;
  localparam logic [PIH_W-1:0] PI_HALF_Q30 = PIH_W'(1686629713);
  localparam longint ONE_Q30 = 64'd1 << Q_FRAC;

  localparam int TERM_W     = 32;
  localparam int ACC_W      = 34;
  localparam int NUM_TERMS  = 6;
  localparam int TERM_IDX_W = $clog2(NUM_TERMS);
  localparam int RECIP_W    = 33;

  // Reciprocals for the exact division of a 32-bit value by (2k)(2k+1).
  localparam logic [RECIP_W-1:0] RECIP_M [NUM_TERMS] = '{
    RECIP_W'(((64'd1 << 35) + 64'd5) / 64'd6),
    RECIP_W'(((64'd1 << 37) + 64'd19) / 64'd20),
    RECIP_W'(((64'd1 << 38) + 64'd41) / 64'd42),
    RECIP_W'(((64'd1 << 39) + 64'd71) / 64'd72),
    RECIP_W'(((64'd1 << 39) + 64'd109) / 64'd110),
    RECIP_W'(((64'd1 << 40) + 64'd155) / 64'd156)
  };
  localparam int RECIP_SH [NUM_TERMS] = '{35, 37, 38, 39, 39, 40};

  localparam int SINE_SH = 6;
  localparam int SINE_W  = Q_FRAC + 2 - SINE_SH;

  localparam int VOLT_W  = 21;
  localparam int VCLAMP  = 707767;
  localparam int TH10    = 655350;
  localparam int TH5     = 327675;
  localparam logic [VOLT_W-1:0] MIN_RESET = VOLT_W'(0);
  localparam logic [VOLT_W-1:0] MAX_RESET = VOLT_W'(327680);

  localparam int CODE_W  = 16;
  localparam int NUM_SH  = 25;
  localparam int PROD_W  = VOLT_W + SINE_W;
  localparam int X_W     = PROD_W + CODE_W - NUM_SH;
  localparam int PART_W  = X_W - CODE_W;
  localparam int RNG_W   = 3;

  localparam logic REG_MIN_VOLTAGE = 1'b0;
  localparam logic REG_MAX_VOLTAGE = 1'b1;

  typedef enum logic [RNG_W-1:0] {
    RNG_0_5V,
    RNG_0_10V,
    RNG_0_10V8,
    RNG_PM_5V,
    RNG_PM_10V,
    RNG_PM_10V8
  } range_e;

  typedef struct packed {
    range_e              rng;
    logic [VOLT_W-1:0]   span;
    logic [VOLT_W-1:0]   off;
    logic [VOLT_W-1:0]   diff;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               quad;
    logic [TERM_W-1:0]        t2;
    logic [TERM_W-1:0]        term;
    logic signed [ACC_W-1:0]  acc;
  } taylor_t;

  typedef struct packed {
    logic               sat;
    logic [PART_W-1:0]  part;
    logic [CODE_W-1:0]  low;
    logic [CODE_W-1:0]  quo;
  } div_t;

  function automatic logic [VOLT_W-1:0] span_of(range_e rng);
    logic [VOLT_W-1:0] s;
    unique case (rng)
      RNG_0_5V:    s = VOLT_W'(327680);
      RNG_0_10V:   s = VOLT_W'(655360);
      RNG_0_10V8:  s = VOLT_W'(707789);
      RNG_PM_5V:   s = VOLT_W'(655360);
      RNG_PM_10V:  s = VOLT_W'(1310720);
      RNG_PM_10V8: s = VOLT_W'(1415578);
      default:     s = VOLT_W'(327680);
    endcase
    return s;
  endfunction

  function automatic logic [VOLT_W-1:0] half_of(range_e rng);
    logic [VOLT_W-1:0] h;
    unique case (rng)
      RNG_PM_5V:   h = VOLT_W'(327680);
      RNG_PM_10V:  h = VOLT_W'(655360);
      RNG_PM_10V8: h = VOLT_W'(707789);
      default:     h = VOLT_W'(0);
    endcase
    return h;
  endfunction

endpackage

@@ hdl/dac_sine_code_generator_top.sv @@
// Sine DAC code generator. Each item on the slave stream carries a phase index and yields one
// item on the master stream with the 16-bit DAC code of that sine sample and the chosen output
// range. One item is taken per clock while s_axis_tready is high. The sine value comes out of a
// chain of six series cells, and the code comes out of a chain of sixteen one-bit divider
// cells. The whole pipeline halts only while both the output register and the skid register
// hold results; s_axis_tready is low exactly then. The user must write minimum and maximum
// voltages through the cfg port only while no item is in flight; the block itself does not
// enforce this.
module dac_sine_code_generator_top import dscg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [VOLT_W-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [9:0] phase_index
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] dac_code
  output logic [2:0]        m_axis_tuser    // [2:0] range_select
);

  localparam int NUM_DIV = CODE_W;

  cfg_t cfg;
  logic en;

  logic in_vld_q, th_vld_q, sq_vld_q, t1_vld_q, t2_vld_q, m1_vld_q, m2_vld_q, m3_vld_q;
  logic d0_vld_q;
  logic [PH_W-1:0] phase_q;
  logic [1:0] th_quad_q, t1_quad_q;
  logic [TERM_W-1:0] theta_q;
  taylor_t sq_q;
  logic signed [ACC_W-1:0] t1_acc_q;
  logic [SINE_W-1:0] sine_q;
  logic [PROD_W-1:0] m1_prod_q, m2_num_q;
  logic [X_W-1:0] x_q;
  div_t d0_q;

  logic [1:0] quad;
  logic [ANG_W-1:0] ang_r, ang;
  logic [ANG_W+PIH_W-1:0] th_prod;
  logic [2*TERM_W-1:0] th_sq;
  taylor_t sq_d;
  logic [Q_FRAC:0] sc;
  logic [Q_FRAC+1:0] sine_sum;
  logic [PROD_W+CODE_W-1:0] big;
  div_t d0_d;

  logic [NUM_TERMS:0] tc_vld;
  taylor_t tc_data [NUM_TERMS+1];
  logic [NUM_DIV:0] dc_vld;
  div_t dc_data [NUM_DIV+1];

  logic out_vld_q, skid_vld_q;
  logic [CODE_W-1:0] out_code_q, skid_code_q, last_code;
  range_e out_rng_q, skid_rng_q;

  dscg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign en = !skid_vld_q;
  assign s_axis_tready = en;

  always_comb begin
    quad    = phase_q[PH_W-1 -: 2];
    ang_r   = ANG_W'({phase_q[PH_W-3:0], 2'b00});
    ang     = quad[0] ? ANG_W'(SPP) - ang_r : ang_r;
    th_prod = (ANG_W+PIH_W)'(ang) * (ANG_W+PIH_W)'(PI_HALF_Q30);

    th_sq     = theta_q * theta_q;
    sq_d.quad = th_quad_q;
    sq_d.t2   = th_sq[Q_FRAC +: TERM_W];
    sq_d.term = theta_q;
    sq_d.acc  = '0;

    if (t1_acc_q < 0) begin
      sc = '0;
    end else if (t1_acc_q > ONE_Q30) begin
      sc = (Q_FRAC+1)'(ONE_Q30);
    end else begin
      sc = t1_acc_q[Q_FRAC:0];
    end
    if (t1_quad_q[1]) begin
      sine_sum = (Q_FRAC+2)'(ONE_Q30) - (Q_FRAC+2)'(sc);
    end else begin
      sine_sum = (Q_FRAC+2)'(ONE_Q30) + (Q_FRAC+2)'(sc);
    end

    big = {m2_num_q, CODE_W'(0)} - (PROD_W+CODE_W)'(m2_num_q);

    d0_d.part = x_q[X_W-1 -: PART_W];
    d0_d.sat  = d0_d.part >= PART_W'(cfg.span);
    d0_d.low  = x_q[CODE_W-1:0];
    d0_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      th_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      d0_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
      th_vld_q <= in_vld_q;
      sq_vld_q <= th_vld_q;
      t1_vld_q <= tc_vld[NUM_TERMS];
      t2_vld_q <= t1_vld_q;
      m1_vld_q <= t2_vld_q;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      d0_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_q   <= s_axis_tdata[PH_W-1:0];
      th_quad_q <= quad;
      theta_q   <= th_prod[PH_W +: TERM_W];
      sq_q      <= sq_d;
      t1_quad_q <= tc_data[NUM_TERMS].quad;
      t1_acc_q  <= tc_data[NUM_TERMS].acc + $signed({2'b00, tc_data[NUM_TERMS].term});
      sine_q    <= sine_sum[Q_FRAC+1 -: SINE_W];
      m1_prod_q <= PROD_W'(cfg.diff) * PROD_W'(sine_q);
      m2_num_q  <= m1_prod_q + PROD_W'({cfg.off, NUM_SH'(0)});
      x_q       <= big[NUM_SH +: X_W];
      d0_q      <= d0_d;
    end
  end

  assign tc_vld[0]  = sq_vld_q;
  assign tc_data[0] = sq_q;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_taylor
    dscg_taylor_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (TERM_IDX_W'(k)),
      .vld_i  (tc_vld[k]),
      .data_i (tc_data[k]),
      .vld_o  (tc_vld[k+1]),
      .data_o (tc_data[k+1])
    );
  end

  assign dc_vld[0]  = d0_vld_q;
  assign dc_data[0] = d0_q;

  for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
    dscg_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .span_i (cfg.span),
      .vld_i  (dc_vld[k]),
      .data_i (dc_data[k]),
      .vld_o  (dc_vld[k+1]),
      .data_o (dc_data[k+1])
    );
  end

  assign last_code = dc_data[NUM_DIV].sat ? '1 : dc_data[NUM_DIV].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= dc_vld[NUM_DIV];
    end else if (dc_vld[NUM_DIV]) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_code_q <= skid_code_q;
        out_rng_q  <= skid_rng_q;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_code_q <= last_code;
      out_rng_q  <= cfg.rng;
    end else begin
      skid_code_q <= last_code;
      skid_rng_q  <= cfg.rng;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_rng_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid register filled while the output register was free");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(tc_vld) && $stable(dc_vld))
    else $error("pipeline moved while the skid register was full");

endmodule

@@ hdl/dscg_cfg.sv @@
module dscg_cfg import dscg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [VOLT_W-1:0] cfg_data_i,
  output cfg_t              cfg_o
);

  logic [VOLT_W-1:0] min_q, max_q;
  logic signed [VOLT_W-1:0] mn, mx;
  logic signed [VOLT_W:0] diff_s, off_s;
  range_e rng;
  cfg_t cfg_d, cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_VOLTAGE: min_q <= cfg_data_i;
        REG_MAX_VOLTAGE: max_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    mn = $signed(min_q);
    mx = $signed(max_q);
    if (mn < -VCLAMP) begin
      mn = VOLT_W'(-VCLAMP);
    end
    if (mx > VCLAMP) begin
      mx = VOLT_W'(VCLAMP);
    end
    if (!mn[VOLT_W-1]) begin
      if (mx <= TH5) begin
        rng = RNG_0_5V;
      end else if (mx <= TH10) begin
        rng = RNG_0_10V;
      end else begin
        rng = RNG_0_10V8;
      end
      off_s = {mn[VOLT_W-1], mn};
    end else begin
      if (mn >= -TH5) begin
        rng = RNG_PM_5V;
      end else if (mn >= -TH10) begin
        rng = RNG_PM_10V;
      end else begin
        rng = RNG_PM_10V8;
      end
      off_s = $signed({1'b0, half_of(rng)}) + $signed({mn[VOLT_W-1], mn});
    end
    diff_s = $signed({mx[VOLT_W-1], mx}) - $signed({mn[VOLT_W-1], mn});
    if (diff_s[VOLT_W]) begin
      diff_s = -diff_s;
    end
    cfg_d.rng  = rng;
    cfg_d.span = span_of(rng);
    cfg_d.off  = off_s[VOLT_W-1:0];
    cfg_d.diff = diff_s[VOLT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/dscg_taylor_cell.sv @@
module dscg_taylor_cell import dscg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [TERM_IDX_W-1:0] idx_i,
  input  logic                  vld_i,
  input  taylor_t               data_i,
  output logic                  vld_o,
  output taylor_t               data_o
);

  logic a_vld_q, b_vld_q;
  taylor_t a_d, a_q, b_d, b_q;
  logic [2*TERM_W-1:0] sq_prod;
  logic [TERM_W+RECIP_W-1:0] rc_prod;

  // The incoming term carries this cell's own index, so even cells add it and odd cells
  // subtract it.
  always_comb begin
    sq_prod = data_i.term * data_i.t2;
    a_d = data_i;
    a_d.term = sq_prod[Q_FRAC +: TERM_W];
    if (!idx_i[0]) begin
      a_d.acc = data_i.acc + $signed({2'b00, data_i.term});
    end else begin
      a_d.acc = data_i.acc - $signed({2'b00, data_i.term});
    end
  end

  always_comb begin
    rc_prod = (TERM_W+RECIP_W)'(a_q.term) * (TERM_W+RECIP_W)'(RECIP_M[idx_i]);
    b_d = a_q;
    b_d.term = TERM_W'(rc_prod >> RECIP_SH[idx_i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign data_o = b_q;

endmodule

@@ hdl/dscg_div_cell.sv @@
module dscg_div_cell import dscg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [VOLT_W-1:0] span_i,
  input  logic              vld_i,
  input  div_t              data_i,
  output logic              vld_o,
  output div_t              data_o
);

  logic vld_q;
  div_t d_d, d_q;
  logic [PART_W-1:0] shifted;
  logic ge;

  always_comb begin
    shifted = {data_i.part[PART_W-2:0], data_i.low[CODE_W-1]};
    ge = shifted >= PART_W'(span_i);
    d_d = data_i;
    d_d.part = ge ? shifted - PART_W'(span_i) : shifted;
    d_d.low  = {data_i.low[CODE_W-2:0], 1'b0};
    d_d.quo  = {data_i.quo[CODE_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = d_q;

endmodule
